/* hdl/prl_pkg.sv */
// package for the percentile rank lookup: codes, widths and the step rom
`timescale 1ns / 1ps
`default_nettype none

package prl_pkg;

  localparam int DEPTH_DEFAULT = 1024;

  // item kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // fixed result widths and q16 constants
  localparam int RES_W = 17;
  localparam int FRAC_SHIFT = 15;  // 2^16 / 2 folded into the dividend
  localparam logic [RES_W-1:0] Q_ONE  = 17'd65536;
  localparam logic [RES_W-1:0] Q_HALF = 17'd32768;

  // step counter
  localparam int PC_W = 4;

  // datapath operations
  localparam logic [2:0] OP_NOP     = 3'd0;
  localparam logic [2:0] OP_INIT_LO = 3'd1;
  localparam logic [2:0] OP_CMP_LO  = 3'd2;
  localparam logic [2:0] OP_SAVE_LO = 3'd3;
  localparam logic [2:0] OP_CMP_HI  = 3'd4;
  localparam logic [2:0] OP_PREP    = 3'd5;
  localparam logic [2:0] OP_DIV     = 3'd6;
  localparam logic [2:0] OP_DONE    = 3'd7;

  // jump conditions
  localparam logic [2:0] CND_NONE     = 3'd0;
  localparam logic [2:0] CND_CNT_ZERO = 3'd1;
  localparam logic [2:0] CND_MORE     = 3'd2;
  localparam logic [2:0] CND_END      = 3'd3;
  localparam logic [2:0] CND_DIV_MORE = 3'd4;

  // program steps
  localparam logic [PC_W-1:0] STEP_INIT_LO = 4'd0;
  localparam logic [PC_W-1:0] STEP_RD_LO   = 4'd1;
  localparam logic [PC_W-1:0] STEP_CMP_LO  = 4'd2;
  localparam logic [PC_W-1:0] STEP_SAVE_LO = 4'd3;
  localparam logic [PC_W-1:0] STEP_RD_HI   = 4'd4;
  localparam logic [PC_W-1:0] STEP_CMP_HI  = 4'd5;
  localparam logic [PC_W-1:0] STEP_PREP    = 4'd6;
  localparam logic [PC_W-1:0] STEP_DIV     = 4'd7;
  localparam logic [PC_W-1:0] STEP_DONE    = 4'd8;

  typedef struct packed {
    logic [2:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t prog_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_DONE, cond: CND_NONE, target: STEP_INIT_LO};
    unique case (pc)
      STEP_INIT_LO: w = '{op: OP_INIT_LO, cond: CND_CNT_ZERO, target: STEP_SAVE_LO};
      STEP_RD_LO:   w = '{op: OP_NOP,     cond: CND_NONE,     target: STEP_INIT_LO};
      STEP_CMP_LO:  w = '{op: OP_CMP_LO,  cond: CND_MORE,     target: STEP_RD_LO};
      STEP_SAVE_LO: w = '{op: OP_SAVE_LO, cond: CND_CNT_ZERO, target: STEP_PREP};
      STEP_RD_HI:   w = '{op: OP_NOP,     cond: CND_NONE,     target: STEP_INIT_LO};
      STEP_CMP_HI:  w = '{op: OP_CMP_HI,  cond: CND_MORE,     target: STEP_RD_HI};
      STEP_PREP:    w = '{op: OP_PREP,    cond: CND_END,      target: STEP_DONE};
      STEP_DIV:     w = '{op: OP_DIV,     cond: CND_DIV_MORE, target: STEP_DIV};
      STEP_DONE:    w = '{op: OP_DONE,    cond: CND_NONE,     target: STEP_INIT_LO};
      default:      w = '{op: OP_DONE,    cond: CND_NONE,     target: STEP_INIT_LO};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hdl/percentile_rank_lookup.sv */
// percentile rank lookup: user-sorted value table, microcoded rank query
//
// usage: drive kind and value and raise start; the transfer happens at a
// rising edge with start high and busy low. clear empties the table and
// append stores one value at the end (ignored when full); both leave busy
// low and give no result. a query raises busy and later gives one result
// on base_rank and rating, marked by done for exactly one cycle.
// a query runs a short program from a step rom: two binary searches over the
// table memory, each probe a registered memory read followed by a compare,
// then a restoring divide by count minus one, one quotient bit per cycle
// over CW+16 bits. a search takes about log2(count)+1 probes, with
// CW = clog2(DEPTH+1). the end cases (no entry at or below the value, or
// all entries below it) skip the divide. done rises at the edge at which
// busy falls, so the next item may be given while the result is shown.
// synchronous reset empties the table and stops any query; the receiver
// cannot stall, results must be taken when shown.
`timescale 1ns / 1ps
`default_nettype none

module percentile_rank_lookup #(
  parameter int DEPTH = prl_pkg::DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               kind,
  input  wire logic signed [31:0]       value,
  output logic                          done,
  output logic [prl_pkg::RES_W-1:0]     base_rank,
  output logic [prl_pkg::RES_W-1:0]     rating
);
  import prl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = CW + 1 + FRAC_SHIFT;
  localparam int DCW = $clog2(NW + 1);

  logic [31:0]     mem [DEPTH];
  logic [31:0]     rdata;
  logic [31:0]     key;
  logic [CW-1:0]   count;
  logic [PC_W-1:0] pc;
  logic [CW-1:0]   start_idx;
  logic [CW-1:0]   len;
  logic [CW-1:0]   lo;
  logic [CW-1:0]   div;
  logic [CW-1:0]   rem;
  logic [NW-1:0]   quo;
  logic [DCW-1:0]  div_cnt;
  logic            zero_case;
  logic            one_case;

  ctrl_t           cw;
  logic            accept;
  logic            take;
  logic [CW-1:0]   half;
  logic [CW-1:0]   mid;
  logic            pass;
  logic [CW-1:0]   start_next;
  logic [CW-1:0]   len_next;
  logic [CW:0]     num;
  logic [CW:0]     trial;
  logic            qbit;
  logic [CW-1:0]   rem_next;
  logic [NW-1:0]   rate_sum;
  logic            end_now;

  assign accept = start && !busy;
  assign cw = prog_word(pc);

  // search arithmetic
  always_comb begin
    half = len >> 1;
    mid = start_idx + half;
    if (cw.op == OP_CMP_HI) begin
      pass = rdata <= key;
    end else begin
      pass = rdata < key;
    end
    if (pass) begin
      start_next = mid + CW'(1);
      len_next = len - half - CW'(1);
    end else begin
      start_next = start_idx;
      len_next = half;
    end
  end

  // divide step and result shaping
  always_comb begin
    num = {1'b0, lo} + {1'b0, start_idx} - (CW+1)'(1);
    end_now = (start_idx == '0) || (lo >= count);
    trial = {rem, quo[NW-1]};
    qbit = trial >= {1'b0, div};
    if (qbit) begin
      rem_next = CW'(trial - {1'b0, div});
    end else begin
      rem_next = trial[CW-1:0];
    end
    rate_sum = NW'(Q_HALF) + (quo >> 1);
  end

  always_comb begin
    unique case (cw.cond)
      CND_NONE:     take = 1'b0;
      CND_CNT_ZERO: take = count == '0;
      CND_MORE:     take = len_next != '0;
      CND_END:      take = end_now;
      CND_DIV_MORE: take = div_cnt != DCW'(1);
      default:      take = 1'b0;
    endcase
  end

  // table memory: stored as order keys so unsigned compares keep signed order
  always_ff @(posedge clk) begin
    if (accept && kind == KIND_APPEND && count < CW'(DEPTH)) begin
      mem[count[AW-1:0]] <= {~value[31], value[30:0]};
    end
    rdata <= mem[mid[AW-1:0]];
  end

  // control: sequencer, count, strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
      pc <= STEP_INIT_LO;
    end else begin
      done <= 1'b0;
      if (accept) begin
        case (kind)
          KIND_CLEAR: count <= '0;
          KIND_APPEND: begin
            if (count < CW'(DEPTH)) begin
              count <= count + CW'(1);
            end
          end
          KIND_QUERY: begin
            busy <= 1'b1;
            pc <= STEP_INIT_LO;
          end
          default: ;
        endcase
      end else if (busy) begin
        if (cw.op == OP_DONE) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        pc <= take ? cw.target : pc + PC_W'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      key <= {~value[31], value[30:0]};
    end else if (busy) begin
      unique case (cw.op) inside
        OP_INIT_LO: begin
          start_idx <= '0;
          len <= count;
        end
        OP_SAVE_LO: begin
          lo <= start_idx;
          start_idx <= '0;
          len <= count;
        end
        OP_CMP_LO, OP_CMP_HI: begin
          start_idx <= start_next;
          len <= len_next;
        end
        OP_PREP: begin
          zero_case <= start_idx == '0;
          one_case <= lo >= count;
          quo <= {num, FRAC_SHIFT'(0)};
          rem <= '0;
          div <= (count > CW'(1)) ? count - CW'(1) : CW'(1);
          div_cnt <= DCW'(NW);
        end
        OP_DIV: begin
          rem <= rem_next;
          quo <= {quo[NW-2:0], qbit};
          div_cnt <= div_cnt - DCW'(1);
        end
        OP_DONE: begin
          if (zero_case) begin
            base_rank <= '0;
            rating <= Q_HALF;
          end else if (one_case) begin
            base_rank <= Q_ONE;
            rating <= Q_ONE;
          end else begin
            base_rank <= (quo > NW'(Q_ONE)) ? Q_ONE : quo[RES_W-1:0];
            rating <= (rate_sum > NW'(Q_ONE)) ? Q_ONE : rate_sum[RES_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/prl_checker.sv */
// port-level checker for the percentile rank lookup, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module prl_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic [1:0]                    kind,
  input wire logic                          done,
  input wire logic [prl_pkg::RES_W-1:0]     base_rank,
  input wire logic [prl_pkg::RES_W-1:0]     rating
);
  import prl_pkg::*;

  // a query transfer starts work
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == KIND_QUERY |=> busy)
    else $error("query transfer did not raise busy");

  // clear and append finish in the cycle they are taken
  a_other_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind != KIND_QUERY |=> !busy && !done)
    else $error("clear or append raised busy or done");

  // a result closes a running query
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result without a running query");

  // result range and rating tied to base rank
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> base_rank <= Q_ONE && rating == Q_HALF + (base_rank >> 1))
    else $error("result out of range or rating mismatch");

endmodule

bind percentile_rank_lookup prl_checker u_prl_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .kind(kind),
  .done(done),
  .base_rank(base_rank),
  .rating(rating)
);

`default_nettype wire
